[design/ccc_pkg.sv]
// Shared types, constants and the month length table of the calendar clock.
package ccc_pkg;

    // One calendar time. The year sits in the lowest bits so that the
    // packed struct matches the stream word layout directly.
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_time;

    localparam int TIME_W  = $bits(t_time);
    localparam int TDATA_W = ((TIME_W + 7) / 8) * 8;

    // Command codes carried in tuser.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Counter limits.
    localparam logic [6:0] SEC_LIMIT  = 7'd60;
    localparam logic [6:0] MIN_LIMIT  = 7'd60;
    localparam logic [5:0] HOUR_LIMIT = 6'd24;
    localparam logic [4:0] MONTH_LAST = 5'd12;
    localparam logic [7:0] YEAR_LAST  = 8'd99;

    localparam logic [3:0] MONTH_FEB = 4'd2;

    // Time after reset: 17:41:28 on the first of May, year 24.
    localparam t_time RESET_TIME = '{
        second: 6'd28,
        minute: 6'd41,
        hour:   5'd17,
        day:    5'd1,
        month:  4'd5,
        year:   7'd24
    };

    // Days in a month for a non-leap year. Codes that are not months
    // give a length of zero.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[design/calendar_clock_counter_unit.sv]
// Top level of the calendar clock: input register, time state and result word.
//
//   Channel  Direction  Handshake        Payload
//   s_axis   in         tvalid / tready  tdata = load time, tuser = command
//   m_axis   out        tvalid / tready  tdata = current time
//
// Each accepted word gives exactly one result word, passing from the input
// register into the time state. A new word can be accepted in every cycle
// unless the result stalls; the rate is one word per cycle, set by the single
// pass through the carry chain between the time registers and themselves.
// Reset (synchronous, active low) empties both registers and sets the time to
// 17:41:28 on the first of May, year 24. When the result is not taken, the
// input register holds one further word and then tready falls.
module calendar_clock_counter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata fields from bit 0 up: load_year[6:0], load_month[3:0], load_day[4:0],
    // load_hour[4:0], load_minute[5:0], load_second[5:0], zero fill.
    input  logic [ccc_pkg::TDATA_W-1:0] i_s_axis_tdata,
    // tuser fields: command (0 = one-second tick, 1 = load).
    input  logic                        i_s_axis_tuser,

    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tdata fields from bit 0 up: cur_year[6:0], cur_month[3:0], cur_day[4:0],
    // cur_hour[4:0], cur_minute[5:0], cur_second[5:0], zero fill.
    output logic [ccc_pkg::TDATA_W-1:0] o_m_axis_tdata
);

    // Input register: one word waiting for the time update.
    logic           r_in_valid;
    logic           n_in_valid;
    logic           r_in_cmd;
    ccc_pkg::t_time r_in_load;

    // Time state. It doubles as the result payload, since a result is
    // always the time just after its word.
    ccc_pkg::t_time r_time;
    ccc_pkg::t_time n_time;
    logic           r_out_valid;
    logic           n_out_valid;

    logic           advance;
    logic           in_take;
    ccc_pkg::t_time next_time;

    // The held word moves on when the result slot is empty or being emptied.
    assign advance = r_in_valid && (!r_out_valid || i_m_axis_tready);

    // The input register can take a word when it is empty or moving on.
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    ccc_next u_next (
        .i_cmd  (r_in_cmd),
        .i_cur  (r_time),
        .i_load (r_in_load),
        .o_next (next_time)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_time      = r_time;
        if (advance) begin
            n_in_valid = 1'b0;
        end
        if (in_take) begin
            n_in_valid = 1'b1;
        end
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = 1'b1;
            n_time      = next_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_time      <= ccc_pkg::RESET_TIME;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_time      <= n_time;
        end
    end

    // The payload of the input register needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_load <= ccc_pkg::t_time'(i_s_axis_tdata[ccc_pkg::TIME_W-1:0]);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(ccc_pkg::TDATA_W - ccc_pkg::TIME_W){1'b0}}, r_time};

    // A word that moves on always leaves a result behind it.
    a_advance_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid
    ) else $error("word moved on without a result");

    // tready only falls while a word is held in the input register.
    a_ready_low_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid
    ) else $error("input not ready with an empty input register");

    // The time changes only when a word moves on.
    a_time_only_on_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_time)
    ) else $error("time changed without a word");

    // A tick either steps the seconds by one or wraps them to zero.
    a_tick_seconds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_cmd == ccc_pkg::CMD_TICK)) |=>
            ((r_time.second == 6'd0) ||
             (r_time.second == 6'($past(r_time.second) + 6'd1)))
    ) else $error("tick did not step the seconds");

endmodule

[design/ccc_next.sv]
// Next-time logic of the calendar clock: the carry chain of one tick, or a load.
module ccc_next (
    input  logic           i_cmd,
    input  ccc_pkg::t_time i_cur,
    input  ccc_pkg::t_time i_load,
    output ccc_pkg::t_time o_next
);

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic [4:0] day_lim;
    logic       leap_feb;
    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       day_wrap;
    logic       month_wrap;
    ccc_pkg::t_time tick_time;

    assign sec_inc   = {1'b0, i_cur.second} + 7'd1;
    assign min_inc   = {1'b0, i_cur.minute} + 7'd1;
    assign hour_inc  = {1'b0, i_cur.hour} + 6'd1;
    assign day_inc   = {1'b0, i_cur.day} + 6'd1;
    assign month_inc = {1'b0, i_cur.month} + 5'd1;
    assign year_inc  = {1'b0, i_cur.year} + 8'd1;

    // February gains a day when the year is a multiple of four.
    assign leap_feb = (i_cur.month == ccc_pkg::MONTH_FEB) && (i_cur.year[1:0] == 2'd0);
    assign day_lim  = ccc_pkg::month_len(i_cur.month) + {4'd0, leap_feb};

    assign sec_wrap   = sec_inc >= ccc_pkg::SEC_LIMIT;
    assign min_wrap   = sec_wrap && (min_inc >= ccc_pkg::MIN_LIMIT);
    assign hour_wrap  = min_wrap && (hour_inc >= ccc_pkg::HOUR_LIMIT);
    assign day_wrap   = hour_wrap && (day_inc > {1'b0, day_lim});
    assign month_wrap = day_wrap && (month_inc > ccc_pkg::MONTH_LAST);

    always_comb begin
        tick_time = i_cur;
        tick_time.second = sec_wrap ? 6'd0 : sec_inc[5:0];
        if (sec_wrap) begin
            tick_time.minute = min_wrap ? 6'd0 : min_inc[5:0];
        end
        if (min_wrap) begin
            tick_time.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
        end
        if (hour_wrap) begin
            tick_time.day = day_wrap ? 5'd1 : day_inc[4:0];
        end
        if (day_wrap) begin
            tick_time.month = month_wrap ? 4'd1 : month_inc[3:0];
        end
        if (month_wrap) begin
            tick_time.year = (year_inc > ccc_pkg::YEAR_LAST) ? 7'd0 : year_inc[6:0];
        end
    end

    assign o_next = (i_cmd == ccc_pkg::CMD_LOAD) ? i_load : tick_time;

endmodule
